[rtl/core/gwol_pkg.sv]
// Package for the workgroup occupancy limit block.
// Holds the beat types, status and register codes, flag positions and target decode.
// No dependencies.
`timescale 1ns / 1ps

package gwol_pkg;

  localparam int unsigned DivNumW = 11;
  localparam int unsigned DivDenW = 12;
  localparam int unsigned DivQuoW = 8;

  localparam int unsigned FlWave32   = 0;
  localparam int unsigned FlWgp      = 1;
  localparam int unsigned FlTrap     = 2;
  localparam int unsigned FlDyn12    = 3;
  localparam int unsigned FlDyn125   = 4;
  localparam int unsigned FlTgSplit  = 5;
  localparam int unsigned FlLaunchG  = 6;
  localparam int unsigned FlNamedBar = 7;
  localparam int unsigned FlSharedV  = 8;
  localparam int unsigned FlCluster  = 9;
  localparam int unsigned FlNoDesc   = 10;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StUnsup   = 2'd1,
    StInvalid = 2'd2,
    StRange   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CfgGfxMajor      = 3'd0,
    CfgGfxMinor      = 3'd1,
    CfgGfxStepping   = 3'd2,
    CfgTargetExact   = 3'd3,
    CfgSimdsPerCu    = 3'd4,
    CfgMaxWavesPerCu = 3'd5,
    CfgMaxDynamicLds = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VcOne       = 2'd0,
    VcHalf      = 2'd1,
    VcThird     = 2'd2,
    VcTwoThirds = 2'd3
  } vcode_e;

  typedef enum logic [1:0] {
    LgSmall = 2'd0,
    LgMid   = 2'd1,
    LgBig   = 2'd2
  } lgran_e;

  typedef struct packed {
    logic [10:0] wg_size_x;
    logic [10:0] wg_size_y;
    logic [10:0] wg_size_z;
    logic [31:0] dynamic_lds_bytes;
    logic [31:0] fixed_lds_bytes;
    logic [5:0]  vgpr_blocks;
    logic [3:0]  sgpr_blocks;
    logic [10:0] feature_flags;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] max_workgroups;
  } res_t;

  function automatic logic target_known(logic [3:0] ma, logic [3:0] mi, logic [3:0] st);
    logic ok;
    ok = 1'b0;
    unique case (ma)
      4'd9: begin
        if (mi == 4'd0) begin
          ok = (st == 4'd0) || (st == 4'd2) || (st == 4'd4) || (st == 4'd6) ||
               (st == 4'd8) || (st == 4'd9) || (st == 4'd10) || (st == 4'd12);
        end else if (mi == 4'd4) begin
          ok = (st <= 4'd2);
        end else if (mi == 4'd5) begin
          ok = (st == 4'd0);
        end
      end
      4'd10: ok = ((mi == 4'd1) && (st <= 4'd3)) || ((mi == 4'd3) && (st <= 4'd6));
      4'd11: ok = ((mi == 4'd0) && (st <= 4'd3)) || ((mi == 4'd5) && (st <= 4'd3)) ||
                  ((mi == 4'd7) && (st <= 4'd2));
      4'd12: ok = ((mi == 4'd0) || (mi == 4'd5)) && (st <= 4'd1);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic big_vreg_file(logic [3:0] ma, logic [3:0] mi, logic [3:0] st);
    logic big;
    big = ((ma == 4'd12) && (mi == 4'd0)) ||
          ((ma == 4'd11) && (((mi == 4'd0) && (st <= 4'd1)) || ((mi == 4'd5) && (st == 4'd1))));
    return big;
  endfunction

endpackage

[rtl/core/gwol_div.sv]
// Pipelined restoring divider with a saturating quotient, one quotient bit per stage.
// Depends on gwol_pkg for its default widths.
`timescale 1ns / 1ps

module gwol_div #(
  parameter int unsigned NumW = gwol_pkg::DivNumW,
  parameter int unsigned DenW = gwol_pkg::DivDenW,
  parameter int unsigned QuoW = gwol_pkg::DivQuoW
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  localparam int unsigned TrialW = DenW + QuoW;

  logic [NumW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic            sat_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    localparam int unsigned Bit = QuoW - 1 - k;
    logic [NumW-1:0]   rem_in;
    logic [DenW-1:0]   den_in;
    logic [QuoW-1:0]   quo_in;
    logic              sat_in;
    logic [TrialW-1:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign sat_in = TrialW'(num_i) >= (TrialW'(den_i) << QuoW);
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sat_in = sat_q[k-1];
    end

    assign trial = TrialW'(den_in) << Bit;
    assign take  = !sat_in && (TrialW'(rem_in) >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? NumW'(TrialW'(rem_in) - trial) : rem_in;
      den_q[k] <= den_in;
      sat_q[k] <= sat_in;
      quo_q[k] <= quo_in | (take ? (QuoW'(1) << Bit) : QuoW'(0));
    end
  end

  assign quo_o = sat_q[QuoW-1] ? '1 : quo_q[QuoW-1];

endmodule

[rtl/core/gpu_workgroup_occupancy_limit.sv]
// Top level of the workgroup occupancy limit block: configuration registers and pipeline.
// Depends on gwol_pkg and gwol_div.
//
// Channel   Direction  Handshake                      Beat
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
// request   in         start_i while busy_o is low    req_i (gwol_pkg::req_t)
// result    out        res_valid_o strobe, one cycle  res_o (gwol_pkg::res_t)
//
// A request is taken in every cycle; busy_o stays low.
// Each result passes through two decode stages, an eight-stage divider bank for the
// resource limits, one merge stage, an eight-stage divider for the wave limit, and
// the output register. Reset clears the valid bits and the configuration registers.
`timescale 1ns / 1ps

module gpu_workgroup_occupancy_limit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           start_i,
  output logic           busy_o,
  input  gwol_pkg::req_t req_i,
  output logic           res_valid_o,
  output gwol_pkg::res_t res_o
);

  import gwol_pkg::*;

  localparam int unsigned Latency = 2 * DivQuoW + 4;

  typedef struct packed {
    status_e     status;
    logic [21:0] p1;
    logic [10:0] wz;
    logic [32:0] req_sum;
    logic        lds_over;
    logic        req_zero;
    logic [18:0] lds_bytes;
    logic [8:0]  lds_num;
    lgran_e      gran;
    logic [7:0]  vnum;
    logic [6:0]  vden;
    logic [7:0]  sa;
    logic        sregs_en;
    logic        dynv;
    logic [5:0]  bars;
    logic        wave64;
    logic        cus2;
  } s1_t;

  typedef struct packed {
    status_e     status;
    logic [32:0] p;
    logic [11:0] lds_den;
    logic [8:0]  lds_num;
    logic        lds_over;
    logic        req_zero;
    logic [7:0]  vnum;
    logic [6:0]  vden;
    logic [7:0]  sa;
    logic        sregs_en;
    logic        dynv;
    logic [5:0]  bars;
    logic        wave64;
    logic        cus2;
  } s2_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  bars_lim;
    logic [11:0] wden;
    logic        lds_over;
    logic        req_zero;
    logic        sregs_en;
    logic        dynv;
    logic        cus2;
  } sb1_t;

  typedef struct packed {
    status_e     status;
    logic [10:0] mnum;
    logic [11:0] wden;
    logic [7:0]  other;
  } s4_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] other;
  } sb2_t;

  logic [3:0]  gfx_major_q, gfx_minor_q, gfx_stepping_q, simds_q;
  logic        exact_q;
  logic [6:0]  max_waves_q;
  logic [31:0] max_dyn_q;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  sb1_t sb1_d;
  sb1_t sb1_q [DivQuoW];
  s4_t  s4_d, s4_q;
  sb2_t sb2_q [DivQuoW];
  res_t res_d, res_q;
  logic s1_valid_q, s2_valid_q, s4_valid_q, res_valid_q;
  logic [DivQuoW-1:0] v1_q, v2_q;

  logic [DivQuoW-1:0] lds_quo, vreg_quo, sreg_quo, wps_quo, wave_quo;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gfx_major_q    <= '0;
      gfx_minor_q    <= '0;
      gfx_stepping_q <= '0;
      exact_q        <= 1'b0;
      simds_q        <= '0;
      max_waves_q    <= '0;
      max_dyn_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGfxMajor:      gfx_major_q    <= cfg_data_i[3:0];
        CfgGfxMinor:      gfx_minor_q    <= cfg_data_i[3:0];
        CfgGfxStepping:   gfx_stepping_q <= cfg_data_i[3:0];
        CfgTargetExact:   exact_q        <= cfg_data_i[0];
        CfgSimdsPerCu:    simds_q        <= cfg_data_i[3:0];
        CfgMaxWavesPerCu: max_waves_q    <= cfg_data_i[6:0];
        CfgMaxDynamicLds: max_dyn_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: status decode, profile selection and register allocation sizes.
  always_comb begin
    logic [10:0] fl;
    logic        w32, wgp, f512, big, unsup;
    logic [6:0]  vm;
    logic [7:0]  t3;
    logic [4:0]  sb1;
    vcode_e      vc;

    fl    = req_i.feature_flags;
    w32   = fl[FlWave32];
    wgp   = fl[FlWgp];
    big   = big_vreg_file(gfx_major_q, gfx_minor_q, gfx_stepping_q);
    f512  = ((gfx_minor_q == 4'd0) && (gfx_stepping_q == 4'd10)) ||
            (gfx_minor_q == 4'd4) || (gfx_minor_q == 4'd5);
    unsup = 1'b0;
    vc    = VcOne;

    s1_d          = '0;
    s1_d.p1       = 22'(req_i.wg_size_x) * 22'(req_i.wg_size_y);
    s1_d.wz       = req_i.wg_size_z;
    s1_d.req_sum  = 33'(req_i.dynamic_lds_bytes) + 33'(req_i.fixed_lds_bytes);
    s1_d.req_zero = (s1_d.req_sum == 33'd0);
    s1_d.lds_over = req_i.dynamic_lds_bytes > max_dyn_q;

    if (gfx_major_q == 4'd9) begin
      unsup         = w32 || (f512 && fl[FlTgSplit]);
      s1_d.wave64   = 1'b1;
      s1_d.cus2     = 1'b0;
      s1_d.lds_num  = 9'd128;
      s1_d.gran     = (gfx_minor_q == 4'd5) ? LgMid : LgSmall;
      s1_d.lds_bytes = (gfx_minor_q == 4'd5) ? 19'd163840 : 19'd65536;
      s1_d.vnum     = 8'd64;
      vc            = VcOne;
      s1_d.bars     = 6'd16;
      s1_d.sregs_en = 1'b1;
      s1_d.dynv     = 1'b0;
    end else if ((gfx_major_q == 4'd12) && (gfx_minor_q == 4'd5)) begin
      unsup         = !w32 || wgp || fl[FlLaunchG] || fl[FlNamedBar];
      s1_d.wave64   = 1'b0;
      s1_d.cus2     = 1'b1;
      s1_d.lds_num  = 9'd160;
      s1_d.gran     = LgBig;
      s1_d.lds_bytes = 19'd327680;
      s1_d.vnum     = 8'd64;
      vc            = VcTwoThirds;
      s1_d.bars     = 6'd16;
      s1_d.sregs_en = 1'b0;
      s1_d.dynv     = fl[FlDyn125];
    end else begin
      unsup         = ((gfx_major_q <= 4'd11) && fl[FlSharedV]) ||
                      ((gfx_major_q == 4'd12) && fl[FlLaunchG]);
      s1_d.wave64   = !w32;
      s1_d.cus2     = wgp;
      s1_d.lds_num  = wgp ? 9'd256 : 9'd128;
      s1_d.gran     = LgSmall;
      s1_d.lds_bytes = wgp ? 19'd131072 : 19'd65536;
      if ((gfx_major_q == 4'd10) && (gfx_minor_q == 4'd1)) begin
        s1_d.vnum = 8'd128;
        vc        = VcOne;
      end else if (big) begin
        s1_d.vnum = 8'd64;
        vc        = VcThird;
      end else begin
        s1_d.vnum = 8'd64;
        vc        = VcHalf;
      end
      s1_d.bars     = wgp ? 6'd32 : 6'd16;
      s1_d.sregs_en = 1'b0;
      s1_d.dynv     = (gfx_major_q == 4'd12) && fl[FlDyn12];
    end

    vm = {1'b0, req_i.vgpr_blocks} + 7'd1;
    t3 = '0;
    unique case (vc)
      VcOne:  s1_d.vden = vm;
      VcHalf: s1_d.vden = 7'((8'(vm) + 8'd1) >> 1);
      VcThird: begin
        t3        = 8'(vm) + 8'd2;
        s1_d.vden = 7'((16'(t3) * 16'd171) >> 9);
      end
      VcTwoThirds: begin
        t3        = {vm, 1'b0} + 8'd2;
        s1_d.vden = 7'((16'(t3) * 16'd171) >> 9);
      end
      default: s1_d.vden = vm;
    endcase

    sb1     = {1'b0, req_i.sgpr_blocks} + 5'd1;
    s1_d.sa = (8'((6'(sb1) + 6'd1) >> 1) << 4) + (fl[FlTrap] ? 8'd16 : 8'd0);

    priority if ((req_i.wg_size_x == 11'd0) || (req_i.wg_size_y == 11'd0) ||
                 (req_i.wg_size_z == 11'd0)) begin
      s1_d.status = StInvalid;
    end else if (fl[FlNoDesc]) begin
      s1_d.status = StUnsup;
    end else if (!exact_q || !target_known(gfx_major_q, gfx_minor_q, gfx_stepping_q)) begin
      s1_d.status = StUnsup;
    end else if (unsup || fl[FlCluster]) begin
      s1_d.status = StUnsup;
    end else begin
      s1_d.status = StOk;
    end
  end

  // Stage 2: invocation count and local memory granule count.
  always_comb begin
    logic [18:0] req19;
    logic [10:0] r256;
    logic [11:0] kd;

    req19 = s1_q.req_sum[18:0];
    r256  = 11'((20'(req19) + 20'd255) >> 8);
    unique case (s1_q.gran)
      LgSmall: kd = 12'((20'(req19) + 20'd511) >> 9);
      LgMid:   kd = 12'(((25'(r256) + 25'd4) * 25'd13108) >> 16);
      LgBig:   kd = 12'((20'(req19) + 20'd2047) >> 11);
      default: kd = '1;
    endcase

    s2_d          = '0;
    s2_d.status   = s1_q.status;
    s2_d.p        = 33'(s1_q.p1) * 33'(s1_q.wz);
    s2_d.lds_den  = (s1_q.req_sum > 33'(s1_q.lds_bytes)) ? 12'h800 : kd;
    s2_d.lds_num  = s1_q.lds_num;
    s2_d.lds_over = s1_q.lds_over;
    s2_d.req_zero = s1_q.req_zero;
    s2_d.vnum     = s1_q.vnum;
    s2_d.vden     = s1_q.vden;
    s2_d.sa       = s1_q.sa;
    s2_d.sregs_en = s1_q.sregs_en;
    s2_d.dynv     = s1_q.dynv;
    s2_d.bars     = s1_q.bars;
    s2_d.wave64   = s1_q.wave64;
    s2_d.cus2     = s1_q.cus2;
  end

  always_comb begin
    logic [27:0] waves;

    waves = s2_q.wave64 ? 28'((s2_q.p + 33'd63) >> 6) : 28'((s2_q.p + 33'd31) >> 5);
    sb1_d          = '0;
    sb1_d.status   = s2_q.status;
    sb1_d.bars_lim = (waves > 28'd1) ? 8'(s2_q.bars) : 8'hFF;
    sb1_d.wden     = (waves >= 28'h800) ? 12'h800 : waves[11:0];
    sb1_d.lds_over = s2_q.lds_over;
    sb1_d.req_zero = s2_q.req_zero;
    sb1_d.sregs_en = s2_q.sregs_en;
    sb1_d.dynv     = s2_q.dynv;
    sb1_d.cus2     = s2_q.cus2;
  end

  gwol_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_lds (
    .clk_i (clk_i),
    .num_i (DivNumW'(s2_q.lds_num)),
    .den_i (s2_q.lds_den),
    .quo_o (lds_quo)
  );

  gwol_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_vreg (
    .clk_i (clk_i),
    .num_i (DivNumW'(s2_q.vnum)),
    .den_i (DivDenW'(s2_q.vden)),
    .quo_o (vreg_quo)
  );

  gwol_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_sreg (
    .clk_i (clk_i),
    .num_i (DivNumW'(800)),
    .den_i (DivDenW'(s2_q.sa)),
    .quo_o (sreg_quo)
  );

  gwol_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_wps (
    .clk_i (clk_i),
    .num_i (DivNumW'(max_waves_q)),
    .den_i (DivDenW'(simds_q)),
    .quo_o (wps_quo)
  );

  // Merge: per-SIMD wave budget, SIMD consistency and the non-wave limits.
  always_comb begin
    sb1_t        sb;
    logic [DivQuoW-1:0] vl, sl, m, lds_lim;
    logic [4:0]  sd;
    logic [12:0] mprod;
    logic        sim_bad;

    sb      = sb1_q[DivQuoW-1];
    vl      = (sb.dynv || (wps_quo <= vreg_quo)) ? wps_quo : vreg_quo;
    sl      = (sb.sregs_en && (sreg_quo < wps_quo)) ? sreg_quo : wps_quo;
    m       = (vl <= sl) ? vl : sl;
    sd      = sb.cus2 ? {simds_q, 1'b0} : 5'(simds_q);
    mprod   = 13'(m) * 13'(sd);
    sim_bad = (simds_q == 4'd0) || (max_waves_q == 7'd0) ||
              ((12'(wps_quo) * 12'(simds_q)) != 12'(max_waves_q));
    lds_lim = sb.lds_over ? '0 : (sb.req_zero ? '1 : lds_quo);

    s4_d        = '0;
    s4_d.status = sim_bad ? StUnsup : sb.status;
    s4_d.mnum   = mprod[10:0];
    s4_d.wden   = sb.wden;
    s4_d.other  = (sb.bars_lim <= lds_lim) ? sb.bars_lim : lds_lim;
  end

  gwol_div #(.NumW(DivNumW), .DenW(DivDenW), .QuoW(DivQuoW)) u_div_wave (
    .clk_i (clk_i),
    .num_i (s4_q.mnum),
    .den_i (s4_q.wden),
    .quo_o (wave_quo)
  );

  always_comb begin
    sb2_t       sb;
    logic [7:0] lim;

    sb    = sb2_q[DivQuoW-1];
    lim   = (wave_quo <= sb.other) ? wave_quo : sb.other;
    res_d = '0;
    res_d.status         = sb.status;
    res_d.max_workgroups = (sb.status == StOk) ? 16'(lim) : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    sb1_q[0] <= sb1_d;
    s4_q     <= s4_d;
    sb2_q[0] <= '{status: s4_q.status, other: s4_q.other};
    res_q    <= res_d;
    for (int i = 1; i < DivQuoW; i++) begin
      sb1_q[i] <= sb1_q[i-1];
      sb2_q[i] <= sb2_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      v1_q        <= '0;
      s4_valid_q  <= 1'b0;
      v2_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start_i && !busy_o;
      s2_valid_q  <= s1_valid_q;
      v1_q        <= {v1_q[DivQuoW-2:0], s2_valid_q};
      s4_valid_q  <= v1_q[DivQuoW-1];
      v2_q        <= {v2_q[DivQuoW-2:0], s4_valid_q};
      res_valid_q <= v2_q[DivQuoW-1];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i, Latency))
    else $error("result beat without a request beat at the pipeline latency");

  a_err_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != StOk)) |-> (res_o.max_workgroups == 16'd0))
    else $error("error status with a nonzero workgroup count");

  a_no_range_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status != StRange))
    else $error("out of range status produced");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == StOk)) |-> (res_o.max_workgroups <= 16'd254))
    else $error("workgroup count above the wave slot bound");

endmodule

[sim/gwol_occupancy_checker.sv]
// Checker for the workgroup occupancy limit block: tracks register writes, predicts each result.
// Compares every result beat with the oldest predicted one. Depends on gwol_pkg.
`timescale 1ns / 1ps

module gwol_occupancy_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           start_i,
  input  logic           busy_i,
  input  gwol_pkg::req_t req_i,
  input  logic           res_valid_i,
  input  gwol_pkg::res_t res_i,
  output int             err_count_o,
  output int             pending_o
);
  import gwol_pkg::*;

  logic [3:0]  gfx_major, gfx_minor, gfx_stepping;
  logic        target_exact;
  logic [3:0]  simds_per_cu;
  logic [6:0]  max_waves_per_cu;
  logic [31:0] max_dynamic_lds;
  res_t        expected_q[$];
  int          errors;

  assign err_count_o = errors;

  function automatic logic version_known(logic [3:0] ma, logic [3:0] mi, logic [3:0] st);
    case (ma)
      4'd9: begin
        if (mi == 0) return st inside {0, 2, 4, 6, 8, 9, 10, 12};
        if (mi == 4) return st <= 2;
        if (mi == 5) return st == 0;
        return 1'b0;
      end
      4'd10: return (mi == 1 && st <= 3) || (mi == 3 && st <= 6);
      4'd11: return (mi == 0 && st <= 3) || (mi == 5 && st <= 3) || (mi == 7 && st <= 2);
      4'd12: return (mi == 0 || mi == 5) && st <= 1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [63:0] ceil_to(logic [63:0] v, logic [63:0] g);
    return ((v + g - 1) / g) * g;
  endfunction

  function automatic logic [63:0] min_of(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic res_t workgroup_limit(req_t r);
    res_t        res;
    logic [10:0] fl;
    logic        w32, f512, wgp, big, dynv;
    logic [63:0] wave, cus, lds, ldsg, vregs, venc, vgran, bars, sregs, trap;
    logic [63:0] waves, simd_dom, wps, lim, req_bytes, va, vl, sa, sl;
    fl = r.feature_flags;
    w32 = fl[FlWave32];
    dynv = 1'b0;
    sregs = 0;
    trap = 0;
    res.status = StOk;
    res.max_workgroups = '0;
    if (simds_per_cu == 0 || max_waves_per_cu == 0 ||
        (max_waves_per_cu % simds_per_cu) != 0) begin
      res.status = StUnsup;
      return res;
    end
    if (r.wg_size_x == 0 || r.wg_size_y == 0 || r.wg_size_z == 0) begin
      res.status = StInvalid;
      return res;
    end
    if (fl[FlNoDesc] || !target_exact || !version_known(gfx_major, gfx_minor, gfx_stepping)) begin
      res.status = StUnsup;
      return res;
    end
    if (gfx_major == 9) begin
      f512 = (gfx_minor == 0 && gfx_stepping == 10) || gfx_minor == 4 || gfx_minor == 5;
      if (w32 || (f512 && fl[FlTgSplit])) begin
        res.status = StUnsup;
        return res;
      end
      wave = 64;
      cus = 1;
      lds = (gfx_minor == 5) ? 160 * 1024 : 64 * 1024;
      ldsg = (gfx_minor == 5) ? 1280 : 512;
      vregs = f512 ? 512 : 256;
      venc = f512 ? 8 : 4;
      vgran = venc;
      bars = 16;
      sregs = 800;
      trap = fl[FlTrap] ? 16 : 0;
    end else if (gfx_major == 12 && gfx_minor == 5) begin
      if (!w32 || fl[FlWgp] || fl[FlLaunchG] || fl[FlNamedBar]) begin
        res.status = StUnsup;
        return res;
      end
      wave = 32;
      cus = 2;
      lds = 320 * 1024;
      ldsg = 2048;
      vregs = 1536;
      venc = 16;
      vgran = 24;
      bars = 16;
      dynv = fl[FlDyn125];
    end else begin
      wgp = fl[FlWgp];
      big = (gfx_major == 12 && gfx_minor == 0) ||
            (gfx_major == 11 && ((gfx_minor == 0 && gfx_stepping <= 1) ||
                                 (gfx_minor == 5 && gfx_stepping == 1)));
      if ((gfx_major <= 11 && fl[FlSharedV]) || (gfx_major == 12 && fl[FlLaunchG])) begin
        res.status = StUnsup;
        return res;
      end
      wave = w32 ? 32 : 64;
      if (gfx_major == 10 && gfx_minor == 1) vgran = w32 ? 8 : 4;
      else if (big) vgran = w32 ? 24 : 12;
      else vgran = w32 ? 16 : 8;
      cus = wgp ? 2 : 1;
      lds = wgp ? 128 * 1024 : 64 * 1024;
      ldsg = 512;
      vregs = big ? (w32 ? 1536 : 768) : (w32 ? 1024 : 512);
      venc = w32 ? 8 : 4;
      bars = wgp ? 32 : 16;
      dynv = (gfx_major == 12) && fl[FlDyn12];
    end
    if (fl[FlCluster]) begin
      res.status = StUnsup;
      return res;
    end
    waves = (64'(r.wg_size_x) * 64'(r.wg_size_y) * 64'(r.wg_size_z) + wave - 1) / wave;
    simd_dom = 64'(simds_per_cu) * cus;
    wps = 64'(max_waves_per_cu) / 64'(simds_per_cu);
    lim = (wps * simd_dom) / waves;
    if (waves > 1) lim = min_of(lim, bars);
    if (r.dynamic_lds_bytes > max_dynamic_lds) begin
      lim = 0;
    end else begin
      req_bytes = 64'(r.fixed_lds_bytes) + 64'(r.dynamic_lds_bytes);
      if (req_bytes != 0) lim = min_of(lim, lds / ceil_to(req_bytes, ldsg));
    end
    if (!dynv) begin
      va = ceil_to((64'(r.vgpr_blocks) + 1) * venc, vgran);
      vl = min_of(wps, vregs / va);
      lim = min_of(lim, (vl * simd_dom) / waves);
    end
    if (sregs != 0) begin
      sa = ceil_to((64'(r.sgpr_blocks) + 1) * 8, 16) + trap;
      sl = min_of(wps, sregs / sa);
      lim = min_of(lim, (sl * simd_dom) / waves);
    end
    res.max_workgroups = lim[15:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gfx_major <= '0;
      gfx_minor <= '0;
      gfx_stepping <= '0;
      target_exact <= 1'b0;
      simds_per_cu <= '0;
      max_waves_per_cu <= '0;
      max_dynamic_lds <= '0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgGfxMajor:      gfx_major <= cfg_data_i[3:0];
          CfgGfxMinor:      gfx_minor <= cfg_data_i[3:0];
          CfgGfxStepping:   gfx_stepping <= cfg_data_i[3:0];
          CfgTargetExact:   target_exact <= cfg_data_i[0];
          CfgSimdsPerCu:    simds_per_cu <= cfg_data_i[3:0];
          CfgMaxWavesPerCu: max_waves_per_cu <= cfg_data_i[6:0];
          CfgMaxDynamicLds: max_dynamic_lds <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_q.push_back(workgroup_limit(req_i));
      if (res_valid_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected: status %0d count %0d",
                                    res_i.status, res_i.max_workgroups));
        end else begin
          if (res_i.status !== expected_q[0].status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      res_i.status, expected_q[0].status));
          if (res_i.max_workgroups !== expected_q[0].max_workgroups)
            report_mismatch($sformatf("max_workgroups %0d, expected %0d",
                                      res_i.max_workgroups, expected_q[0].max_workgroups));
          void'(expected_q.pop_front());
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

[sim/gpu_workgroup_occupancy_limit_test.sv]
// Testbench top for the workgroup occupancy limit block: clock, reset, stimulus and verdict.
// Depends on gwol_pkg, gpu_workgroup_occupancy_limit and gwol_occupancy_checker.
`timescale 1ns / 1ps

module gpu_workgroup_occupancy_limit_test;
  import gwol_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int Drain = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        res_valid;
  res_t        res;
  int          err_count, pending, idle_cycles;
  int          burst_left = 0;

  always #1 clk = ~clk;

  gpu_workgroup_occupancy_limit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .start_i(start), .busy_o(busy), .req_i(req),
    .res_valid_o(res_valid), .res_o(res)
  );

  gwol_occupancy_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .start_i(start), .busy_i(busy), .req_i(req),
    .res_valid_i(res_valid), .res_i(res),
    .err_count_o(err_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || res_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("gpu_workgroup_occupancy_limit_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_quiet();
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_regs(logic [3:0] ma, logic [3:0] mi, logic [3:0] st, logic ex,
                            logic [3:0] simds, logic [6:0] waves, logic [31:0] maxdyn);
    logic [31:0] vals[7];
    vals = '{32'(ma), 32'(mi), 32'(st), 32'(ex), 32'(simds), 32'(waves), maxdyn};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_e'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_req(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [31:0] lds_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(1, 4096);
      default: return $urandom_range(0, 70000);
    endcase
  endfunction

  function automatic logic [10:0] dim_value();
    case ($urandom_range(0, 9))
      0: return 11'd1024;
      1: return $urandom_range(1, 1024);
      2, 3: return 11'd1;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.wg_size_x = dim_value();
    r.wg_size_y = ($urandom_range(0, 2) == 0) ? dim_value() : 11'd1;
    r.wg_size_z = ($urandom_range(0, 3) == 0) ? dim_value() : 11'd1;
    if ($urandom_range(0, 30) == 0) r.wg_size_y = '0;
    r.dynamic_lds_bytes = lds_value();
    r.fixed_lds_bytes = lds_value();
    r.vgpr_blocks = $urandom_range(0, 63);
    r.sgpr_blocks = $urandom_range(0, 15);
    if ($urandom_range(0, 4) == 0) begin
      r.feature_flags = $urandom_range(0, 2047);
    end else begin
      r.feature_flags = '0;
      r.feature_flags[FlWave32] = $urandom_range(0, 1);
      r.feature_flags[FlWgp] = $urandom_range(0, 1);
      r.feature_flags[FlTrap] = $urandom_range(0, 1);
      r.feature_flags[FlDyn12] = $urandom_range(0, 3) == 0;
      r.feature_flags[FlDyn125] = $urandom_range(0, 3) == 0;
      r.feature_flags[FlTgSplit] = $urandom_range(0, 3) == 0;
      r.feature_flags[FlLaunchG] = $urandom_range(0, 7) == 0;
      r.feature_flags[FlNamedBar] = $urandom_range(0, 7) == 0;
      r.feature_flags[FlSharedV] = $urandom_range(0, 7) == 0;
    end
    return r;
  endfunction

  task automatic directed_reqs();
    req_t r;
    r = '{wg_size_x: 11'd64, wg_size_y: 11'd1, wg_size_z: 11'd1, dynamic_lds_bytes: '0,
          fixed_lds_bytes: '0, vgpr_blocks: '0, sgpr_blocks: '0, feature_flags: '0};
    send_req(r);
    r.wg_size_x = 11'd1024; r.wg_size_y = 11'd1024; r.wg_size_z = 11'd1024;
    r.vgpr_blocks = 6'd63; r.sgpr_blocks = 4'd15;
    send_req(r);
    r.wg_size_x = 11'd0; send_req(r);
    r.wg_size_x = 11'd8; r.wg_size_y = 11'd0; send_req(r);
    r.wg_size_y = 11'd8; r.wg_size_z = 11'd0; send_req(r);
    r.wg_size_z = 11'd1;
    r.dynamic_lds_bytes = '1; r.fixed_lds_bytes = '1; send_req(r);
    r.dynamic_lds_bytes = '0; r.fixed_lds_bytes = 32'd1; send_req(r);
    r.fixed_lds_bytes = '0;
    for (int b = 0; b < 11; b++) begin
      r.feature_flags = 11'(1) << b;
      r.vgpr_blocks = 6'(b * 5);
      r.sgpr_blocks = 4'(b);
      send_req(r);
    end
    r.feature_flags = '1; send_req(r);
  endtask

  task automatic run_phase(logic [3:0] ma, logic [3:0] mi, logic [3:0] st, logic ex,
                           logic [3:0] simds, logic [6:0] waves, logic [31:0] maxdyn,
                           int n);
    start <= 1'b0;
    burst_left = 0;
    wait_quiet();
    write_regs(ma, mi, st, ex, simds, waves, maxdyn);
    for (int i = 0; i < n; i++) begin
      req_t r;
      r = random_req();
      if (ma == 12 && mi == 5 && $urandom_range(0, 1) == 0) begin
        r.feature_flags[FlWave32] = 1'b1;
        r.feature_flags[FlWgp] = 1'b0;
      end
      if (ma == 9 && $urandom_range(0, 1) == 0) r.feature_flags[FlWave32] = 1'b0;
      send_req(r);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_reqs();
    run_phase(4'd10, 4'd3, 4'd0, 1'b1, 4'd2, 7'd32, 32'd65536, 10);
    directed_reqs();
    run_phase(4'd9, 4'd0, 4'd0, 1'b1, 4'd4, 7'd40, '1, 50);
    run_phase(4'd9, 4'd0, 4'd10, 1'b1, 4'd4, 7'd32, 32'd4096, 40);
    run_phase(4'd9, 4'd4, 4'd2, 1'b1, 4'd4, 7'd32, '1, 40);
    run_phase(4'd9, 4'd5, 4'd0, 1'b1, 4'd8, 7'd64, '1, 45);
    run_phase(4'd10, 4'd1, 4'd3, 1'b1, 4'd2, 7'd40, '1, 40);
    run_phase(4'd10, 4'd3, 4'd6, 1'b1, 4'd2, 7'd32, 32'd70000, 40);
    run_phase(4'd11, 4'd0, 4'd1, 1'b1, 4'd2, 7'd32, '1, 45);
    run_phase(4'd11, 4'd5, 4'd1, 1'b1, 4'd2, 7'd32, '1, 40);
    run_phase(4'd11, 4'd7, 4'd2, 1'b1, 4'd1, 7'd1, '1, 30);
    run_phase(4'd12, 4'd0, 4'd1, 1'b1, 4'd2, 7'd32, '1, 45);
    run_phase(4'd12, 4'd5, 4'd0, 1'b1, 4'd4, 7'd64, '1, 55);
    run_phase(4'd12, 4'd5, 4'd1, 1'b1, 4'd8, 7'd64, '0, 30);
    run_phase(4'd15, 4'd15, 4'd15, 1'b1, 4'd4, 7'd64, '1, 15);
    run_phase(4'd11, 4'd0, 4'd0, 1'b0, 4'd4, 7'd64, '1, 15);
    run_phase(4'd11, 4'd0, 4'd0, 1'b1, 4'd0, 7'd64, '1, 15);
    run_phase(4'd11, 4'd0, 4'd0, 1'b1, 4'd4, 7'd0, '1, 15);
    run_phase(4'd11, 4'd0, 4'd0, 1'b1, 4'd3, 7'd64, '1, 15);
    run_phase(4'd9, 4'd0, 4'd2, 1'b1, 4'd15, 7'd127, '1, 15);
    run_phase(4'd10, 4'd3, 4'd0, 1'b1, 4'd2, 7'd32, 32'd65536, 40);
    start <= 1'b0;
    wait_quiet();
    if (err_count == 0) begin
      $display("gpu_workgroup_occupancy_limit_test: done, clean");
    end else begin
      $display("gpu_workgroup_occupancy_limit_test: done, errors");
    end
    $finish;
  end

endmodule
